@@ design/separable_alpha_blur_macros.svh @@
// Assertion macros for the separable alpha blur checker.
// Used by separable_alpha_blur_chk only.
`ifndef SEPARABLE_ALPHA_BLUR_MACROS_SVH
`define SEPARABLE_ALPHA_BLUR_MACROS_SVH

// Implication checked every clock, disabled while reset is active.
`define SAB_ASSERT_IMPL(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is active.
`define SAB_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

@@ design/sab_pkg.sv @@
// Package for the separable alpha blur: action codes, sequencer states, image
// and kernel limits and fixed field widths. No dependencies.
package sab_pkg;

    typedef enum logic [1:0] {
        ACT_LOAD_TAP  = 2'd0,
        ACT_WRITE_PIX = 2'd1,
        ACT_RUN       = 2'd2,
        ACT_READ_PIX  = 2'd3
    } action_t;

    localparam logic [1:0] CFG_WIDTH   = 2'd0;
    localparam logic [1:0] CFG_HEIGHT  = 2'd1;
    localparam logic [1:0] CFG_SUPPORT = 2'd2;

    // The coordinate, tap index and register ports are sized for these limits.
    localparam int MAX_WIDTH   = 128;
    localparam int MAX_HEIGHT  = 128;
    localparam int MAX_SUPPORT = 63;

    localparam int MID_W = 24;
    localparam int PIX_W = 8;
    localparam int TAP_W = 16;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ_WAIT,
        ST_RES,
        ST_ROW_START,
        ST_ROW_TAP,
        ST_ROW_MAC,
        ST_ROW_STORE,
        ST_COL_START,
        ST_COL_TAP,
        ST_COL_MAC,
        ST_COL_STORE
    } state_t;

endpackage

@@ design/separable_alpha_blur.sv @@
// Separable alpha blur: usage
// Input channel (in_valid/in_stall) carries one action per transaction: load
// a kernel tap, write a pixel, run the blur, or read a pixel. A read returns
// one transaction on the output channel (out_valid/out_stall) with alpha_out;
// the other actions give none. The configuration channel (cfg_valid/cfg_ready)
// sets image width, height and support radius; write it only while idle.
// Tap load and pixel write finish on acceptance; a read passes the registered
// memory read and ST_READ_WAIT before its result in ST_RES. A run stalls the
// input until both passes end: every output sample runs 2s+1 taps through the
// single shared multiply-accumulate unit, each tap a memory read step then a
// multiply and add step, plus a clear and a store step, in the row pass and
// again in the column pass. Accumulator and memory port set this order.
// in_stall stays high while an action is in progress. The result is held in
// an output register until taken; a stalled output keeps the block waiting.
// Reset (rst_n low, asynchronous) returns the registers to 128, 128, 0 and
// the sequencer to idle. Pixel, intermediate and tap memories are not
// cleared; they must be written before use.
module separable_alpha_blur (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  action,
    input  logic [6:0]  tap_index,
    input  logic [15:0] tap_weight,
    input  logic [6:0]  column,
    input  logic [6:0]  row,
    input  logic [7:0]  alpha_in,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  alpha_out,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    localparam int MAX_WIDTH   = sab_pkg::MAX_WIDTH;
    localparam int MAX_HEIGHT  = sab_pkg::MAX_HEIGHT;
    localparam int MAX_SUPPORT = sab_pkg::MAX_SUPPORT;
    localparam int XW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int YW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int TDEP  = 2 * MAX_SUPPORT + 1;
    localparam int TW    = $clog2(TDEP + 1);
    localparam int SW    = $clog2(MAX_SUPPORT + 1);
    // Signed coordinate width covering -MAX_SUPPORT .. max dim + MAX_SUPPORT.
    localparam int CW    = ((XW > YW) ? XW : YW) + SW + 3;
    localparam int ACCW  = 64;

    logic [7:0] width_reg, height_reg;
    logic [5:0] support_reg;

    logic [sab_pkg::PIX_W-1:0] pix_mem [DEPTH];
    logic [sab_pkg::MID_W-1:0] mid_mem [DEPTH];
    logic [sab_pkg::TAP_W-1:0] tap_mem [TDEP];

    sab_pkg::state_t state_reg, state_next;
    logic [XW:0] x_reg, x_next;
    logic [YW:0] y_reg, y_next;
    logic [TW-1:0] t_reg, t_next;
    logic [ACCW-1:0] acc_reg, acc_next;
    logic [7:0] res_reg, res_next;
    logic       rd_in_reg, rd_in_next;
    logic       smp_ok_reg, smp_ok_next;

    // Effective (saturated) dimensions.
    logic [XW:0] w_eff;
    logic [YW:0] h_eff;
    logic [SW-1:0] s_eff;
    logic [TW-1:0] t_last;

    always_comb
    begin
        if (32'(width_reg) > 32'(MAX_WIDTH))
            w_eff = (XW+1)'(MAX_WIDTH);
        else
            w_eff = (XW+1)'(width_reg);
        if (32'(height_reg) > 32'(MAX_HEIGHT))
            h_eff = (YW+1)'(MAX_HEIGHT);
        else
            h_eff = (YW+1)'(height_reg);
        if (32'(support_reg) > 32'(MAX_SUPPORT))
            s_eff = SW'(MAX_SUPPORT);
        else
            s_eff = SW'(support_reg);
        t_last = TW'({s_eff, 1'b0});
    end

    // Sample position p = pos + s - t for the current tap.
    logic signed [CW-1:0] p_row, p_col;
    logic row_ok, col_ok;
    always_comb
    begin
        p_row  = $signed(CW'(x_reg)) + $signed(CW'(s_eff)) - $signed(CW'(t_reg));
        p_col  = $signed(CW'(y_reg)) + $signed(CW'(s_eff)) - $signed(CW'(t_reg));
        row_ok = (p_row >= 0) && (p_row < $signed(CW'(w_eff)));
        col_ok = (p_col >= 0) && (p_col < $signed(CW'(h_eff)));
    end

    logic in_acc, out_acc;
    assign in_acc    = in_valid && !in_stall;
    assign out_acc   = out_valid && !out_stall;
    assign in_stall  = (state_reg != sab_pkg::ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = (state_reg == sab_pkg::ST_RES);
    assign alpha_out = res_reg;

    logic in_inside;
    assign in_inside = (32'(column) < 32'(MAX_WIDTH)) && (32'(row) < 32'(MAX_HEIGHT));

    logic [AW-1:0] in_addr;
    assign in_addr = AW'(32'(row) * 32'(MAX_WIDTH) + 32'(column));

    // Memory read address selection.
    logic [AW-1:0] rd_addr;
    logic [XW-1:0] px_idx;
    logic [YW-1:0] py_idx;
    always_comb
    begin
        px_idx = XW'(p_row);
        py_idx = YW'(p_col);
        if (state_reg == sab_pkg::ST_ROW_TAP)
            rd_addr = AW'(32'(y_reg[YW-1:0]) * 32'(MAX_WIDTH) + 32'(px_idx));
        else if (state_reg == sab_pkg::ST_COL_TAP)
            rd_addr = AW'(32'(py_idx) * 32'(MAX_WIDTH) + 32'(x_reg[XW-1:0]));
        else
            rd_addr = in_addr;
    end

    logic [AW-1:0] cur_addr;
    assign cur_addr = AW'(32'(y_reg[YW-1:0]) * 32'(MAX_WIDTH) + 32'(x_reg[XW-1:0]));

    logic [sab_pkg::PIX_W-1:0] pix_rd_reg;
    logic [sab_pkg::MID_W-1:0] mid_rd_reg;
    logic [sab_pkg::TAP_W-1:0] tap_rd_reg;

    // Row pass saturation and column pass rounding.
    logic [sab_pkg::MID_W-1:0] mid_sat;
    logic [ACCW-1:0] rnd;
    logic [7:0] pix_clamp;
    always_comb
    begin
        mid_sat = (acc_reg > ACCW'(24'hFFFFFF)) ? 24'hFFFFFF : acc_reg[23:0];
        rnd = acc_reg + (ACCW'(1) << 31);
        pix_clamp = (rnd[ACCW-1:32] > (ACCW-32)'(255)) ? 8'd255 : rnd[39:32];
    end

    // Shared multiply-accumulate: tap times sample.
    logic [ACCW-1:0] mac_prod;
    always_comb
    begin
        if (state_reg == sab_pkg::ST_ROW_MAC)
            mac_prod = ACCW'(tap_rd_reg * 24'(pix_rd_reg));
        else
            mac_prod = ACCW'(40'(tap_rd_reg) * 40'(mid_rd_reg));
    end

    always_ff @(posedge clk)
    begin
        if (in_acc && action == sab_pkg::ACT_LOAD_TAP && 32'(tap_index) < TDEP)
            tap_mem[tap_index[TW-1:0]] <= tap_weight;
        if (in_acc && action == sab_pkg::ACT_WRITE_PIX && in_inside)
            pix_mem[in_addr] <= alpha_in;
        if (state_reg == sab_pkg::ST_ROW_STORE)
            mid_mem[cur_addr] <= mid_sat;
        if (state_reg == sab_pkg::ST_COL_STORE)
            pix_mem[cur_addr] <= pix_clamp;
        pix_rd_reg <= pix_mem[rd_addr];
        mid_rd_reg <= mid_mem[rd_addr];
        tap_rd_reg <= tap_mem[t_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg   <= 8'd128;
            height_reg  <= 8'd128;
            support_reg <= 6'd0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                sab_pkg::CFG_WIDTH:   width_reg   <= cfg_data;
                sab_pkg::CFG_HEIGHT:  height_reg  <= cfg_data;
                sab_pkg::CFG_SUPPORT: support_reg <= cfg_data[5:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sab_pkg::ST_IDLE;
            x_reg     <= '0;
            y_reg     <= '0;
            t_reg     <= '0;
            acc_reg   <= '0;
            res_reg   <= '0;
            rd_in_reg <= 1'b0;
            smp_ok_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            x_reg     <= x_next;
            y_reg     <= y_next;
            t_reg     <= t_next;
            acc_reg   <= acc_next;
            res_reg   <= res_next;
            rd_in_reg <= rd_in_next;
            smp_ok_reg <= smp_ok_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        t_next     = t_reg;
        acc_next   = acc_reg;
        res_next   = res_reg;
        rd_in_next = rd_in_reg;
        smp_ok_next = smp_ok_reg;
        case (state_reg)
            sab_pkg::ST_IDLE:
            begin
                if (in_acc)
                begin
                    case (action)
                        sab_pkg::ACT_READ_PIX:
                        begin
                            rd_in_next = in_inside;
                            state_next = sab_pkg::ST_READ_WAIT;
                        end
                        sab_pkg::ACT_RUN:
                        begin
                            if (w_eff != '0 && h_eff != '0)
                            begin
                                x_next = '0;
                                y_next = '0;
                                state_next = sab_pkg::ST_ROW_START;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            sab_pkg::ST_READ_WAIT:
            begin
                res_next   = rd_in_reg ? pix_rd_reg : 8'd0;
                state_next = sab_pkg::ST_RES;
            end
            sab_pkg::ST_RES:
            begin
                if (out_acc)
                    state_next = sab_pkg::ST_IDLE;
            end
            sab_pkg::ST_ROW_START:
            begin
                acc_next = '0;
                t_next   = '0;
                state_next = sab_pkg::ST_ROW_TAP;
            end
            sab_pkg::ST_ROW_TAP:
            begin
                smp_ok_next = row_ok;
                state_next = sab_pkg::ST_ROW_MAC;
            end
            sab_pkg::ST_ROW_MAC:
            begin
                if (smp_ok_reg)
                    acc_next = acc_reg + mac_prod;
                if (t_reg == t_last)
                    state_next = sab_pkg::ST_ROW_STORE;
                else
                begin
                    t_next = t_reg + 1'b1;
                    state_next = sab_pkg::ST_ROW_TAP;
                end
            end
            sab_pkg::ST_ROW_STORE:
            begin
                state_next = sab_pkg::ST_ROW_START;
                if (x_reg + 1'b1 == w_eff)
                begin
                    x_next = '0;
                    if (y_reg + 1'b1 == h_eff)
                    begin
                        y_next = '0;
                        state_next = sab_pkg::ST_COL_START;
                    end
                    else
                        y_next = y_reg + 1'b1;
                end
                else
                    x_next = x_reg + 1'b1;
            end
            sab_pkg::ST_COL_START:
            begin
                acc_next = '0;
                t_next   = '0;
                state_next = sab_pkg::ST_COL_TAP;
            end
            sab_pkg::ST_COL_TAP:
            begin
                smp_ok_next = col_ok;
                state_next = sab_pkg::ST_COL_MAC;
            end
            sab_pkg::ST_COL_MAC:
            begin
                if (smp_ok_reg)
                    acc_next = acc_reg + mac_prod;
                if (t_reg == t_last)
                    state_next = sab_pkg::ST_COL_STORE;
                else
                begin
                    t_next = t_reg + 1'b1;
                    state_next = sab_pkg::ST_COL_TAP;
                end
            end
            sab_pkg::ST_COL_STORE:
            begin
                state_next = sab_pkg::ST_COL_START;
                if (y_reg + 1'b1 == h_eff)
                begin
                    y_next = '0;
                    if (x_reg + 1'b1 == w_eff)
                    begin
                        x_next = '0;
                        state_next = sab_pkg::ST_IDLE;
                    end
                    else
                        x_next = x_reg + 1'b1;
                end
                else
                    y_next = y_reg + 1'b1;
            end
            default: state_next = sab_pkg::ST_IDLE;
        endcase
    end

endmodule

@@ design/separable_alpha_blur_chk.sv @@
// Port-level checker for the separable alpha blur, bound to the top level.
// Depends on separable_alpha_blur_macros.svh and sab_pkg.
`include "separable_alpha_blur_macros.svh"

module separable_alpha_blur_chk (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic [1:0] action,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] alpha_out
);

    // A read transaction produces its result after passing the read wait state.
    `SAB_ASSERT_IMPL(a_read_result, clk, rst_n,
        in_valid && !in_stall && action == sab_pkg::ACT_READ_PIX, ##2 out_valid,
        "read gave no result")
    // No new input is taken while a result is pending.
    `SAB_ASSERT_IMPL(a_busy_on_result, clk, rst_n, out_valid, in_stall,
        "input taken while result pending")
    // A stalled result keeps its value.
    `SAB_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall,
        out_valid && $stable(alpha_out), "stalled result changed")
    // Non-read actions never produce a result in the next cycle.
    `SAB_ASSERT_NEXT(a_no_spurious, clk, rst_n,
        in_valid && !in_stall && action != sab_pkg::ACT_READ_PIX, !out_valid,
        "spurious result")

endmodule

bind separable_alpha_blur separable_alpha_blur_chk u_chk (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .action(action), .out_valid(out_valid), .out_stall(out_stall),
    .alpha_out(alpha_out)
);
